### rtl/maze_wall_merge_engine_core_assert.svh
// Assertion macros shared by the maze wall merge engine RTL.
`ifndef MAZE_WALL_MERGE_ENGINE_CORE_ASSERT_SVH
`define MAZE_WALL_MERGE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication.
`define MWM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mwm assertion failed (same cycle)");

// Next-cycle implication.
`define MWM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mwm assertion failed (next cycle)");

`endif

### rtl/mwm_pkg.sv
// Shared constants, types and helpers of the maze wall merge engine.
package mwm_pkg;

    localparam int COORD_W   = 6;
    localparam int MAX_DIM   = 63;
    localparam int DIM_MIN   = 5;
    localparam int DIM_CAP   = (MAX_DIM - 1) | 1;
    localparam int CELL_W    = 11;
    localparam int LABEL_W   = 10;
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    localparam logic [COORD_W-1:0] DIM_RESET = COORD_W'(21);
    localparam logic [CELL_W-1:0]  CELL_WALL = '1;
    localparam logic [CELL_W-1:0]  CELL_OPEN = '0;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic OP_INIT = 1'b0;
    localparam logic OP_WALL = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_RD_KEEP,
        S_RD_DROP,
        S_CMP,
        S_SCAN,
        S_SCAN_LAST,
        S_OUT
    } state_t;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } cmd_t;

    typedef struct packed {
        logic opened;
        logic done;
        logic bad;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    function automatic logic [COORD_W-1:0] eff_dim(input logic [COORD_W-1:0] raw);
        logic [COORD_W-1:0] d;
        d = raw | COORD_W'(1);
        if (d < COORD_W'(DIM_MIN))
        begin
            d = COORD_W'(DIM_MIN);
        end
        if (d > COORD_W'(DIM_CAP))
        begin
            d = COORD_W'(DIM_CAP);
        end
        return d;
    endfunction

endpackage

### rtl/mwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/mwm_ctrl.sv
// Sequencer: grid rebuild sweep, wall check and relabel scan over the cell RAM.
`include "maze_wall_merge_engine_core_assert.svh"

module mwm_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  mwm_pkg::cmd_t               cmd,
    output logic                        idle,
    output logic                        res_valid,
    input  logic                        res_take,
    output mwm_pkg::result_t            result,
    output mwm_pkg::mem_req_t           mem_req,
    input  logic [mwm_pkg::CELL_W-1:0]  rdata
);

    localparam int EXT_W = mwm_pkg::COORD_W + 1;

    mwm_pkg::state_t                state_reg, state_next;
    mwm_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [mwm_pkg::COORD_W-1:0]    cx_reg, cx_next;
    logic [mwm_pkg::COORD_W-1:0]    cy_reg, cy_next;
    logic [mwm_pkg::LABEL_W-1:0]    n_reg, n_next;
    logic [mwm_pkg::LABEL_W-1:0]    count_reg, count_next;
    logic [mwm_pkg::CELL_W-1:0]     keep_reg, keep_next;
    logic [mwm_pkg::CELL_W-1:0]     drop_reg, drop_next;
    logic                           pend_reg, pend_next;
    logic [mwm_pkg::ADDR_W-1:0]     pend_addr_reg, pend_addr_next;
    logic                           opened_reg, opened_next;
    logic                           bad_reg, bad_next;

    logic                           wall_bad;
    logic [mwm_pkg::LABEL_W-1:0]    n_inc;
    logic [mwm_pkg::COORD_W-1:0]    w_m1, w_m2, h_m1, h_m2;
    logic [mwm_pkg::ADDR_W-1:0]     keep_addr, drop_addr;

    assign wall_bad = (cmd.x == '0) || (cmd.y == '0)
                   || (EXT_W'(cmd.x) + EXT_W'(2) > EXT_W'(cmd.w))
                   || (EXT_W'(cmd.y) + EXT_W'(2) > EXT_W'(cmd.h))
                   || !(cmd.x[0] ^ cmd.y[0]);

    assign n_inc = n_reg + mwm_pkg::LABEL_W'(1);
    assign w_m1  = cmd_reg.w - mwm_pkg::COORD_W'(1);
    assign w_m2  = cmd_reg.w - mwm_pkg::COORD_W'(2);
    assign h_m1  = cmd_reg.h - mwm_pkg::COORD_W'(1);
    assign h_m2  = cmd_reg.h - mwm_pkg::COORD_W'(2);

    always_comb
    begin
        if (cmd_reg.x[0])
        begin
            keep_addr = {cmd_reg.x, cmd_reg.y - mwm_pkg::COORD_W'(1)};
            drop_addr = {cmd_reg.x, cmd_reg.y + mwm_pkg::COORD_W'(1)};
        end
        else
        begin
            keep_addr = {cmd_reg.x - mwm_pkg::COORD_W'(1), cmd_reg.y};
            drop_addr = {cmd_reg.x + mwm_pkg::COORD_W'(1), cmd_reg.y};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mwm_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        n_reg         <= n_next;
        keep_reg      <= keep_next;
        drop_reg      <= drop_next;
        pend_addr_reg <= pend_addr_next;
        opened_reg    <= opened_next;
        bad_reg       <= bad_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        n_next         = n_reg;
        count_next     = count_reg;
        keep_next      = keep_reg;
        drop_next      = drop_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        opened_next    = opened_reg;
        bad_next       = bad_reg;
        mem_req        = '0;
        res_valid      = 1'b0;

        unique case (state_reg)
            mwm_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    cx_next     = '0;
                    cy_next     = '0;
                    n_next      = '0;
                    opened_next = 1'b0;
                    bad_next    = 1'b0;
                    if (cmd.op == mwm_pkg::OP_INIT)
                    begin
                        state_next = mwm_pkg::S_INIT;
                    end
                    else if (wall_bad)
                    begin
                        bad_next   = 1'b1;
                        state_next = mwm_pkg::S_OUT;
                    end
                    else
                    begin
                        state_next = mwm_pkg::S_RD_KEEP;
                    end
                end
            end

            mwm_pkg::S_INIT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = {cx_reg, cy_reg};
                if (cx_reg[0] && cy_reg[0])
                begin
                    n_next        = n_inc;
                    mem_req.wdata = {1'b0, n_inc};
                end
                else if (cx_reg == mwm_pkg::COORD_W'(1) && cy_reg == '0)
                begin
                    mem_req.wdata = mwm_pkg::CELL_W'(1);
                end
                else if (cx_reg == w_m2 && cy_reg == h_m1)
                begin
                    // exit opening takes the final label count
                    mem_req.wdata = {1'b0, n_reg};
                end
                else
                begin
                    mem_req.wdata = mwm_pkg::CELL_WALL;
                end
                if (cy_reg == h_m1)
                begin
                    cy_next = '0;
                    if (cx_reg == w_m1)
                    begin
                        count_next = n_reg;
                        state_next = mwm_pkg::S_OUT;
                    end
                    else
                    begin
                        cx_next = cx_reg + mwm_pkg::COORD_W'(1);
                    end
                end
                else
                begin
                    cy_next = cy_reg + mwm_pkg::COORD_W'(1);
                end
            end

            mwm_pkg::S_RD_KEEP:
            begin
                mem_req.raddr = keep_addr;
                state_next    = mwm_pkg::S_RD_DROP;
            end

            mwm_pkg::S_RD_DROP:
            begin
                mem_req.raddr = drop_addr;
                keep_next     = rdata;
                state_next    = mwm_pkg::S_CMP;
            end

            mwm_pkg::S_CMP:
            begin
                if (rdata == keep_reg)
                begin
                    state_next = mwm_pkg::S_OUT;
                end
                else
                begin
                    drop_next     = rdata;
                    mem_req.we    = 1'b1;
                    mem_req.waddr = {cmd_reg.x, cmd_reg.y};
                    mem_req.wdata = mwm_pkg::CELL_OPEN;
                    cx_next       = mwm_pkg::COORD_W'(1);
                    cy_next       = mwm_pkg::COORD_W'(1);
                    state_next    = mwm_pkg::S_SCAN;
                end
            end

            mwm_pkg::S_SCAN:
            begin
                mem_req.raddr  = {cx_reg, cy_reg};
                pend_next      = 1'b1;
                pend_addr_next = {cx_reg, cy_reg};
                if (pend_reg && rdata == drop_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pend_addr_reg;
                    mem_req.wdata = keep_reg;
                end
                if (cy_reg == h_m2)
                begin
                    cy_next = mwm_pkg::COORD_W'(1);
                    if (cx_reg == w_m2)
                    begin
                        state_next = mwm_pkg::S_SCAN_LAST;
                    end
                    else
                    begin
                        cx_next = cx_reg + mwm_pkg::COORD_W'(2);
                    end
                end
                else
                begin
                    cy_next = cy_reg + mwm_pkg::COORD_W'(2);
                end
            end

            mwm_pkg::S_SCAN_LAST:
            begin
                if (pend_reg && rdata == drop_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pend_addr_reg;
                    mem_req.wdata = keep_reg;
                end
                opened_next = 1'b1;
                if (count_reg != '0)
                begin
                    count_next = count_reg - mwm_pkg::LABEL_W'(1);
                end
                state_next = mwm_pkg::S_OUT;
            end

            mwm_pkg::S_OUT:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = mwm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mwm_pkg::S_IDLE;
            end
        endcase
    end

    assign idle          = (state_reg == mwm_pkg::S_IDLE);
    assign result.opened = opened_reg;
    assign result.done   = (count_reg == mwm_pkg::LABEL_W'(1));
    assign result.bad    = bad_reg;

    `MWM_ASSERT_IMP(a_scan_odd_cells, clk, rst_n, mem_req.we && state_reg == mwm_pkg::S_SCAN, mem_req.waddr[mwm_pkg::COORD_W] && mem_req.waddr[0])
    `MWM_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && !res_take, res_valid && $stable(result))
    `MWM_ASSERT_IMP(a_flags_excl, clk, rst_n, res_valid, !(result.opened && result.bad))
    `MWM_ASSERT_NXT(a_count_no_rise, clk, rst_n, state_reg == mwm_pkg::S_SCAN_LAST, count_reg <= $past(count_reg))

endmodule

### rtl/maze_wall_merge_engine_core.sv
// Init item sweeps every cell; wall item reads both neighbour cells and, when they differ,
// opens the wall and relabels; a bad position skips this. Result sits in the output register.
// Throughput: one item at a time, next item taken once the result leaves the sequencer.
// Relabel scan is bound by the single read port of the cell RAM, one cell per cycle.
// Reset: control, region count and dimensions (21 x 21) reset; cell RAM is not cleared,
// its contents are defined only after an init item.
module maze_wall_merge_engine_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         opcode,
    input  logic [mwm_pkg::COORD_W-1:0]  pos_x,
    input  logic [mwm_pkg::COORD_W-1:0]  pos_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         opened,
    output logic                         done_res,
    output logic                         bad_position,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [mwm_pkg::COORD_W-1:0]  cfg_data
);

    logic [mwm_pkg::COORD_W-1:0] width_reg;
    logic [mwm_pkg::COORD_W-1:0] height_reg;
    logic                        out_valid_reg;
    mwm_pkg::result_t            result_reg;

    mwm_pkg::cmd_t               cmd;
    mwm_pkg::result_t            result;
    mwm_pkg::mem_req_t           mem_req;
    logic [mwm_pkg::CELL_W-1:0]  rdata;
    logic                        idle;
    logic                        res_valid;
    logic                        res_take;

    assign cfg_ready = 1'b1;
    assign in_ready  = idle;
    assign res_take  = !out_valid_reg || out_ready;

    assign cmd.op = opcode;
    assign cmd.x  = pos_x;
    assign cmd.y  = pos_y;
    assign cmd.w  = mwm_pkg::eff_dim(width_reg);
    assign cmd.h  = mwm_pkg::eff_dim(height_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mwm_pkg::DIM_RESET;
            height_reg <= mwm_pkg::DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mwm_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                mwm_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign opened       = result_reg.opened;
    assign done_res     = result_reg.done;
    assign bad_position = result_reg.bad;

    mwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && in_ready),
        .cmd       (cmd),
        .idle      (idle),
        .res_valid (res_valid),
        .res_take  (res_take),
        .result    (result),
        .mem_req   (mem_req),
        .rdata     (rdata)
    );

    mwm_ram #(
        .WIDTH (mwm_pkg::CELL_W),
        .DEPTH (mwm_pkg::MEM_DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

endmodule
